@@ rtl/core/tlmd_pkg.sv @@
// Shared definitions for the type-length message deframer.
// Result kinds, header geometry and the length decode result type.
// No dependencies.
`timescale 1ns / 1ps

package tlmd_pkg;

  localparam int TYPE_BYTES            = 4;
  localparam int DEFAULT_LENGTH_DIGITS = 4;
  localparam int MSG_LEN_W             = 16;
  localparam int MSG_TYPE_W            = 8 * TYPE_BYTES;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic                 ok;
    logic [MSG_LEN_W-1:0] value;
  } len_decode_t;

endpackage

@@ rtl/core/tlmd_if.sv @@
// Valid/ready channels of the deframer: raw byte stream in, results out.
// Depends on tlmd_pkg.
`timescale 1ns / 1ps

interface tlmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tlmd_result_if;
  import tlmd_pkg::*;

  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic [MSG_TYPE_W-1:0] msg_type;
  logic [MSG_LEN_W-1:0]  msg_length;
  logic [7:0]            payload_byte;
  logic                  last;

  modport source (output valid, output kind, output msg_type, output msg_length,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input msg_type, input msg_length,
                  input payload_byte, input last, output ready);
endinterface

@@ rtl/core/type_length_message_deframer_unit.sv @@
// Top level of the type-length message deframer: header capture, payload
// framing and the result register. Depends on tlmd_pkg, tlmd_if and
// tlmd_len_decode.
`timescale 1ns / 1ps

// Channel   Role   Transaction
// --------  -----  ---------------------------------------------------------
// stream    sink   one raw byte of the incoming frame stream (in_byte)
// message   source one result: payload byte, empty message or length error
//
// One byte is taken per clock when the result register is free or being
// drained in the same cycle; a result is registered and shows in the cycle
// after its byte. The length text is decoded combinationally in the cycle
// its last character arrives. Reset (rst, synchronous) returns the block
// to expecting a header. A stall on message holds the result and holds
// stream off only while the result register stays full.

module type_length_message_deframer_unit #(
  parameter int LENGTH_DIGITS = tlmd_pkg::DEFAULT_LENGTH_DIGITS
) (
  input  logic          clk,
  input  logic          rst,
  tlmd_byte_if.sink     stream,
  tlmd_result_if.source message
);
  import tlmd_pkg::*;

  localparam int HW = $clog2(TYPE_BYTES + LENGTH_DIGITS);
  localparam logic [HW-1:0] HDR_TYPE_END = HW'(TYPE_BYTES);
  localparam logic [HW-1:0] HDR_LAST     = HW'(TYPE_BYTES + LENGTH_DIGITS - 1);

  // Frame state.
  logic                          in_payload;
  logic [HW-1:0]                 header_count;
  logic [MSG_TYPE_W-1:0]         type_word;
  logic [LENGTH_DIGITS-1:0][7:0] length_chars;
  logic [LENGTH_DIGITS-1:0][7:0] length_chars_next;
  logic [MSG_LEN_W-1:0]          frame_length;
  logic [MSG_LEN_W-1:0]          bytes_left;
  logic [MSG_LEN_W-1:0]          bytes_left_dec;

  // Result register.
  logic                  out_valid;
  kind_t                 out_kind;
  logic [MSG_TYPE_W-1:0] out_type;
  logic [MSG_LEN_W-1:0]  out_length;
  logic [7:0]            out_byte;
  logic                  out_last;

  len_decode_t decoded;
  logic        take;
  logic        header_done;
  logic        result_load;

  // Accept whenever the result register is empty or drains this cycle.
  assign stream.ready = !out_valid || message.ready;
  assign take         = stream.valid && stream.ready;
  assign header_done  = !in_payload && (header_count == HDR_LAST);
  assign bytes_left_dec = bytes_left - MSG_LEN_W'(1);

  // A payload byte, a bad length or an empty frame loads the result register.
  assign result_load = take &&
                       (in_payload ||
                        (header_done && (!decoded.ok || decoded.value == '0)));

  // Length text as it stands once the current byte is shifted in;
  // position 0 is the first length character received.
  always_comb begin
    for (int i = 0; i < LENGTH_DIGITS - 1; i++) begin
      length_chars_next[i] = length_chars[i+1];
    end
    length_chars_next[LENGTH_DIGITS-1] = stream.in_byte;
  end

  tlmd_len_decode #(
    .LENGTH_DIGITS(LENGTH_DIGITS)
  ) u_len_decode (
    .text   (length_chars_next),
    .result (decoded)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Hold a new result; otherwise clear once the current one drains.
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (message.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (in_payload) begin
          // Every payload byte yields a result; drop back to header at the end.
          if (bytes_left_dec == '0) in_payload <= 1'b0;
        end else if (header_done) begin
          header_count <= '0;
          if (decoded.ok && decoded.value != '0) in_payload <= 1'b1;
        end else begin
          header_count <= header_count + HW'(1);
        end
      end
    end
  end

  // Header fields, counters and result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      if (in_payload) begin
        bytes_left <= bytes_left_dec;
        out_kind   <= KIND_PAYLOAD;
        out_type   <= type_word;
        out_length <= frame_length;
        out_byte   <= stream.in_byte;
        out_last   <= (bytes_left_dec == '0);
      end else begin
        if (header_count < HDR_TYPE_END) begin
          type_word <= {type_word[MSG_TYPE_W-9:0], stream.in_byte};
        end else begin
          length_chars <= length_chars_next;
        end
        if (header_done) begin
          out_type <= type_word;
          out_byte <= 8'd0;
          if (!decoded.ok) begin
            // Malformed length text: report and drop the header.
            frame_length <= '0;
            bytes_left   <= '0;
            out_kind     <= KIND_ERROR;
            out_length   <= '0;
            out_last     <= 1'b0;
          end else begin
            frame_length <= decoded.value;
            bytes_left   <= decoded.value;
            out_kind     <= KIND_EMPTY;
            out_length   <= '0;
            out_last     <= 1'b1;
          end
        end
      end
    end
  end

  assign message.valid        = out_valid;
  assign message.kind         = out_kind;
  assign message.msg_type     = out_type;
  assign message.msg_length   = out_length;
  assign message.payload_byte = out_byte;
  assign message.last         = out_last;

endmodule

@@ rtl/core/tlmd_len_decode.sv @@
// Combinational decode of the ASCII hex length text of a frame header.
// Depends on tlmd_pkg.
`timescale 1ns / 1ps

module tlmd_len_decode #(
  parameter int LENGTH_DIGITS = tlmd_pkg::DEFAULT_LENGTH_DIGITS
) (
  input  logic [LENGTH_DIGITS-1:0][7:0] text,
  output tlmd_pkg::len_decode_t         result
);
  import tlmd_pkg::*;

  localparam int IW = $clog2(LENGTH_DIGITS + 1);
  localparam int DW = 4 * LENGTH_DIGITS;
  localparam int VW = (DW > MSG_LEN_W) ? DW : MSG_LEN_W;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  logic [LENGTH_DIGITS-1:0]      blank;
  logic [LENGTH_DIGITS-1:0]      is_hex;
  logic [LENGTH_DIGITS-1:0][3:0] digit;
  logic [IW-1:0]                 first;
  logic [IW-1:0]                 stop;
  logic [IW-1:0]                 start;
  logic [IW-1:0]                 shift;
  logic                          all_blank;
  logic                          has_sign;
  logic                          has_prefix;
  logic                          bad_char;
  logic [DW-1:0]                 digits;
  logic [VW-1:0]                 wide;

  always_comb begin
    for (int i = 0; i < LENGTH_DIGITS; i++) begin
      blank[i]  = (text[i] == CH_SPACE) || (text[i] == CH_TAB);
      is_hex[i] = 1'b1;
      digit[i]  = 4'd0;
      if (text[i] >= 8'h30 && text[i] <= 8'h39) begin
        digit[i] = text[i][3:0];
      end else if ((text[i] >= 8'h61 && text[i] <= 8'h66) ||
                   (text[i] >= 8'h41 && text[i] <= 8'h46)) begin
        digit[i] = text[i][3:0] + 4'd9;
      end else begin
        is_hex[i] = 1'b0;
      end
    end

    // Trim blanks on both sides: first nonblank, one past last nonblank.
    first = IW'(LENGTH_DIGITS);
    for (int i = LENGTH_DIGITS - 1; i >= 0; i--) begin
      if (!blank[i]) first = IW'(i);
    end
    stop = '0;
    for (int i = 0; i < LENGTH_DIGITS; i++) begin
      if (!blank[i]) stop = IW'(i + 1);
    end
    all_blank = &blank;

    has_sign = 1'b0;
    for (int i = 0; i < LENGTH_DIGITS; i++) begin
      if (IW'(i) == first && (text[i] == CH_PLUS || text[i] == CH_MINUS)) has_sign = 1'b1;
    end

    // Optional 0x / 0X prefix needs at least two characters of text.
    has_prefix = 1'b0;
    for (int i = 0; i < LENGTH_DIGITS - 1; i++) begin
      if (IW'(i) == first && text[i] == CH_ZERO &&
          (text[i+1] == CH_X_LO || text[i+1] == CH_X_UP) &&
          ((IW + 1)'(stop) >= (IW + 1)'(first) + (IW + 1)'(2))) begin
        has_prefix = 1'b1;
      end
    end
    start = has_prefix ? first + IW'(2) : first;

    // Every character left inside the trimmed text must be a hex digit.
    bad_char = 1'b0;
    digits   = '0;
    for (int i = 0; i < LENGTH_DIGITS; i++) begin
      if (IW'(i) >= start && IW'(i) < stop) begin
        if (!is_hex[i]) bad_char = 1'b1;
        digits[4*(LENGTH_DIGITS-1-i) +: 4] = digit[i];
      end
    end

    // Right-align the digits that end at stop.
    shift = IW'(LENGTH_DIGITS) - stop;
    wide  = VW'(digits) >> {shift, 2'b00};

    result.value = wide[MSG_LEN_W-1:0];
    result.ok    = !all_blank && !has_sign && (start != stop) && !bad_char &&
                   ((wide >> MSG_LEN_W) == '0);
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench for the type-length message deframer: drives frames byte by byte,
// predicts every result and compares them in order, field by field.
// Depends on tlmd_pkg, tlmd_if and type_length_message_deframer_unit.
`timescale 1ns / 1ps

module tb_top;
  import tlmd_pkg::*;

  localparam int LEN_DIGITS = DEFAULT_LENGTH_DIGITS;
  localparam int TOTAL_BYTES = 1250;
  localparam int MAX_RANDOM_LEN = 48;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // One byte on the stream channel, plus how the driver treats it.
  typedef struct {
    logic [7:0] data;
    bit         hold;    // wait until every pending result has drained
    bit         steady;  // no idling on either side while this byte is up
  } stream_byte_t;

  // One result on the message channel.
  typedef struct {
    kind_t                 kind;
    logic [MSG_TYPE_W-1:0] msg_type;
    logic [MSG_LEN_W-1:0]  msg_length;
    logic [7:0]            payload_byte;
    logic                  last;
  } frame_result_t;

  logic clk;
  logic rst;

  tlmd_byte_if   stream_if ();
  tlmd_result_if result_if ();

  type_length_message_deframer_unit #(
    .LENGTH_DIGITS(LEN_DIGITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .message (result_if)
  );

  stream_byte_t  pending_bytes[$];
  frame_result_t expected_results[$];
  int            error_count = 0;
  int            driver_idle = 0;
  int            monitor_stall = 0;
  bit            steady_flow = 1'b0;

  // Deframer state as the predictor sees it.
  bit                         pr_in_payload = 1'b0;
  int                         pr_header_count = 0;
  logic [MSG_TYPE_W-1:0]      pr_type_word = '0;
  logic [8*LEN_DIGITS-1:0]    pr_length_text = '0;
  logic [MSG_LEN_W-1:0]       pr_frame_length = '0;
  logic [MSG_LEN_W-1:0]       pr_bytes_left = '0;

  // ---------------------------------------------------------------------------
  // Length text helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] text_char(input logic [8*LEN_DIGITS-1:0] text, input int pos);
    return text[8*(LEN_DIGITS-1-pos) +: 8];
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Hex digit value, or -1 for anything else.
  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Trim blanks, reject signs and empty text, skip an optional 0x prefix,
  // then accept hex digits only. Values above the 16-bit range are errors.
  function automatic len_decode_t decode_length_text(input logic [8*LEN_DIGITS-1:0] text);
    len_decode_t res;
    int          first;
    int          stop;
    int          digit;
    logic [31:0] acc;
    res = '0;
    first = 0;
    stop = LEN_DIGITS;
    acc = '0;
    while (first < stop && is_blank(text_char(text, first))) first++;
    while (stop > first && is_blank(text_char(text, stop - 1))) stop--;
    if (first == stop) return res;
    if (text_char(text, first) == "+" || text_char(text, first) == "-") return res;
    if (stop - first >= 2 && text_char(text, first) == "0" &&
        (text_char(text, first + 1) == "x" || text_char(text, first + 1) == "X"))
      first += 2;
    if (first == stop) return res;
    for (; first < stop; first++) begin
      digit = hex_value(text_char(text, first));
      if (digit < 0) return res;
      acc = (acc << 4) | 32'(digit);
    end
    if (acc > 32'hFFFF) return res;
    res.ok = 1'b1;
    res.value = acc[MSG_LEN_W-1:0];
    return res;
  endfunction

  function automatic logic [7:0] hex_char(input int nib, input bit upper);
    int n;
    n = nib & 15;
    if (n < 10) return 8'("0" + n);
    return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // Mostly well-formed length texts (plain, prefixed, padded), the rest
  // malformed on purpose. Valid lengths stay short so frames stay short.
  function automatic logic [8*LEN_DIGITS-1:0] random_length_text();
    logic [7:0]              c [LEN_DIGITS];
    logic [8*LEN_DIGITS-1:0] text;
    len_decode_t             dec;
    int                      pick;
    int                      val;
    int                      ndig;
    int                      lead;
    do begin
      pick = $urandom_range(0, 99);
      val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_RANDOM_LEN)
                                        : $urandom_range(0, 12);
      for (int i = 0; i < LEN_DIGITS; i++) c[i] = blank_char();
      if (pick < 35) begin
        for (int i = 0; i < LEN_DIGITS; i++)
          c[i] = hex_char(val >> (4 * (LEN_DIGITS - 1 - i)), $urandom_range(0, 1));
      end else if (pick < 50) begin
        c[0] = "0";
        c[1] = $urandom_range(0, 1) ? "x" : "X";
        c[2] = hex_char(val >> 4, $urandom_range(0, 1));
        c[3] = hex_char(val, $urandom_range(0, 1));
      end else if (pick < 65) begin
        // blank padding on either side of one or two digits
        ndig = (val > 15) ? 2 : 1;
        lead = $urandom_range(0, LEN_DIGITS - ndig);
        for (int i = 0; i < ndig; i++)
          c[lead + i] = hex_char(val >> (4 * (ndig - 1 - i)), $urandom_range(0, 1));
      end else if (pick < 71) begin
        // blanks only
      end else if (pick < 77) begin
        c[0] = "0";
        c[1] = $urandom_range(0, 1) ? "x" : "X";
      end else if (pick < 84) begin
        c[0] = $urandom_range(0, 1) ? "+" : "-";
        for (int i = 1; i < LEN_DIGITS; i++) c[i] = hex_char($urandom_range(0, 15), 0);
      end else if (pick < 90) begin
        c[0] = hex_char($urandom_range(0, 15), 1);
        c[2] = hex_char($urandom_range(0, 15), 0);
      end else begin
        for (int i = 0; i < LEN_DIGITS; i++) c[i] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < LEN_DIGITS; i++) text[8*(LEN_DIGITS-1-i) +: 8] = c[i];
      dec = decode_length_text(text);
    end while (dec.ok && dec.value > MAX_RANDOM_LEN);
    return text;
  endfunction

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] data, input bit hold, input bit steady);
    stream_byte_t item;
    item.data = data;
    item.hold = hold;
    item.steady = steady;
    pending_bytes.push_back(item);
  endtask

  // Queue a whole frame: type, length text and as many random payload
  // bytes as the text decodes to (none for an error or an empty frame).
  task automatic add_frame(input logic [MSG_TYPE_W-1:0] type_word,
                           input logic [8*LEN_DIGITS-1:0] text,
                           input bit hold, input bit steady);
    len_decode_t dec;
    dec = decode_length_text(text);
    for (int i = 0; i < TYPE_BYTES; i++)
      add_byte(type_word[8*(TYPE_BYTES-1-i) +: 8], hold && i == 0, steady);
    for (int i = 0; i < LEN_DIGITS; i++)
      add_byte(text_char(text, i), 1'b0, steady);
    if (dec.ok)
      for (int i = 0; i < int'(dec.value); i++)
        add_byte(8'($urandom_range(0, 255)), 1'b0, steady);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: advance the deframer state by one accepted byte and queue
  // the result it causes, if any.
  // ---------------------------------------------------------------------------

  task automatic track_stream_byte(input logic [7:0] b);
    frame_result_t res;
    len_decode_t   dec;
    res.msg_type = pr_type_word;
    res.payload_byte = '0;
    res.last = 1'b0;
    if (pr_in_payload) begin
      pr_bytes_left = pr_bytes_left - 1'b1;
      res.kind = KIND_PAYLOAD;
      res.msg_length = pr_frame_length;
      res.payload_byte = b;
      res.last = (pr_bytes_left == 0);
      expected_results.push_back(res);
      if (pr_bytes_left == 0) pr_in_payload = 1'b0;
      return;
    end
    if (pr_header_count == 0) begin
      pr_type_word = '0;
      pr_length_text = '0;
    end
    if (pr_header_count < TYPE_BYTES)
      pr_type_word = {pr_type_word[MSG_TYPE_W-9:0], b};
    else
      pr_length_text = {pr_length_text[8*LEN_DIGITS-9:0], b};
    pr_header_count++;
    if (pr_header_count < TYPE_BYTES + LEN_DIGITS) return;

    // Header complete: decode the length text.
    pr_header_count = 0;
    dec = decode_length_text(pr_length_text);
    res.msg_type = pr_type_word;
    res.msg_length = '0;
    if (!dec.ok) begin
      res.kind = KIND_ERROR;
      expected_results.push_back(res);
      pr_frame_length = '0;
      pr_bytes_left = '0;
      return;
    end
    pr_frame_length = dec.value;
    pr_bytes_left = dec.value;
    if (dec.value == 0) begin
      res.kind = KIND_EMPTY;
      res.last = 1'b1;
      expected_results.push_back(res);
    end else begin
      pr_in_payload = 1'b1;
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.in_byte = '0;
    result_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stream driver: present queued bytes, predict each one as it is taken,
  // and insert random gaps between transactions.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : stream_driver
    stream_byte_t item;
    if (rst) begin
      stream_if.valid <= 1'b0;
      stream_if.in_byte <= '0;
      steady_flow <= 1'b0;
      driver_idle = 0;
    end else begin
      if (stream_if.valid && stream_if.ready) track_stream_byte(stream_if.in_byte);
      // Advance only when the channel is empty or its byte was just taken;
      // otherwise hold the current byte.
      if (!stream_if.valid || stream_if.ready) begin
        if (driver_idle != 0) begin
          driver_idle--;
          stream_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].hold && expected_results.size() != 0)) begin
          item = pending_bytes.pop_front();
          stream_if.valid <= 1'b1;
          stream_if.in_byte <= item.data;
          steady_flow <= item.steady;
          if (!item.steady && $urandom_range(0, 99) < 40) driver_idle = idle_length();
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall at random, compare each result with the oldest
  // expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      monitor_stall = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d type %0h len %0h",
                   $time, result_if.kind, result_if.msg_type, result_if.msg_length);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          report_field("kind", 32'(want.kind), 32'(result_if.kind));
          report_field("msg_type", want.msg_type, result_if.msg_type);
          report_field("msg_length", 32'(want.msg_length), 32'(result_if.msg_length));
          report_field("payload_byte", 32'(want.payload_byte), 32'(result_if.payload_byte));
          report_field("last", 32'(want.last), 32'(result_if.last));
        end
      end
      if (monitor_stall != 0) begin
        monitor_stall--;
        result_if.ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
        monitor_stall = idle_length() - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int target;

    // Directed frames: field extremes and each decode corner.
    add_frame(32'h0000_0000, "0002", 1'b0, 1'b0);
    add_frame(32'hFFFF_FFFF, " 0x0", 1'b0, 1'b0);            // prefixed zero, empty message
    add_frame(32'h1234_5678, "    ", 1'b0, 1'b0);            // blanks only
    add_frame(32'h89AB_CDEF, {"0x", CH_TAB, CH_SPACE}, 1'b0, 1'b0); // nothing after prefix
    add_frame(32'h0102_0304, "-001", 1'b0, 1'b0);            // minus sign
    add_frame(32'hA5A5_5A5A, "+1  ", 1'b0, 1'b0);            // plus sign
    add_frame(32'h7F80_0180, "1 2 ", 1'b0, 1'b0);            // inner blank
    add_frame(32'hDEAD_BEEF, {"00", 8'h00, "1"}, 1'b0, 1'b0); // NUL inside the digits
    add_frame(32'h5555_AAAA, "g000", 1'b0, 1'b0);            // non-hex letter
    add_frame(32'h0F0F_F0F0, {CH_TAB, "1A", CH_SPACE}, 1'b0, 1'b0);
    add_frame(32'h3C3C_C3C3, "0X3f", 1'b0, 1'b0);

    // Random frames; the first one waits for the directed results to drain.
    target = TOTAL_BYTES;
    add_frame($urandom(), random_length_text(), 1'b1, 1'b0);
    while (pending_bytes.size() < target)
      add_frame($urandom(), random_length_text(), $urandom_range(0, 49) == 0,
                $urandom_range(0, 9) == 0);

    // Last frame, 0x20 payload bytes, streamed without idling.
    add_frame(32'hC3C3_3C3C, "0020", 1'b1, 1'b1);

    // Drain: wait for the last byte and the last result before the verdict.
    while (pending_bytes.size() != 0 || stream_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #10ms;
    $display("timeout, results still pending: %0d", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tlmd_pkg.sv
rtl/core/tlmd_if.sv
rtl/core/tlmd_len_decode.sv
rtl/core/type_length_message_deframer_unit.sv
dv/tb_top.sv
